/* rtl/zrbd_pkg.sv */
// Shared types and constants of the zero-run bitset row decoder.
package zrbd_pkg;

   localparam int unsigned LEN_W  = 9;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned BUF_W  = 56;
   localparam int unsigned FILL_W = 3;
   localparam int unsigned CNT_W  = 4;

   // rsp_tdata: word, then bytes_valid, padded to whole bytes
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [BYTE_W-1:0] NOVIS_BYTE = 8'hFF;

   // req_tuser codes
   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_NO_DATA = 1'b1;

   typedef struct packed {
      logic take_item;  // input transfer this cycle
      logic run_step;   // emit one byte of the pending run
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a word this cycle
      logic starts_run; // the offered item opens a run of bytes
      logic run_last;   // the pending run has one byte left
   } dp_status_type;

endpackage

/* rtl/zrbd_ctrl.sv */
// Controller: sequences item intake and byte runs.
module zrbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  zrbd_pkg::dp_status_type status,
   output zrbd_pkg::ctl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_tready    = (state_ff == ST_IDLE) && status.out_free;
   assign cmd.take_item = req_tvalid && req_tready;
   assign cmd.run_step  = (state_ff == ST_RUN) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take_item && status.starts_run) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd.run_step && status.run_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/zrbd_datapath.sv */
// Datapath: row length register, run decode, byte packer and output register.
module zrbd_datapath #(
   parameter int unsigned ROW_BYTES_MAX = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [zrbd_pkg::LEN_W-1:0]        csr_data,
   input  logic                              req_type,
   input  logic [zrbd_pkg::BYTE_W-1:0]       in_byte,
   input  zrbd_pkg::ctl_cmd_type              cmd,
   output zrbd_pkg::dp_status_type            status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [zrbd_pkg::WORD_W-1:0]       rsp_word,
   output logic [zrbd_pkg::CNT_W-1:0]        rsp_bytes_valid,
   output logic                              rsp_row_end,
   output logic                              rsp_overrun
);

   localparam int unsigned CapInt = (ROW_BYTES_MAX < 256) ? ROW_BYTES_MAX : 256;
   localparam logic [zrbd_pkg::LEN_W-1:0] LEN_CAP = zrbd_pkg::LEN_W'(CapInt);

   logic [zrbd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                        awaiting_ff, awaiting_in;
   logic [zrbd_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [zrbd_pkg::BUF_W-1:0]  buf_ff, buf_in;
   logic [zrbd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [zrbd_pkg::LEN_W-1:0]  run_cnt_ff, run_cnt_in;
   logic [zrbd_pkg::BYTE_W-1:0] run_byte_ff, run_byte_in;
   logic                        run_ov_ff, run_ov_in;
   logic                        out_vld_ff, out_vld_in;
   logic [zrbd_pkg::WORD_W-1:0] out_word_ff, out_word_in;
   logic [zrbd_pkg::CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic                        out_end_ff, out_end_in;
   logic                        out_ov_ff, out_ov_in;

   logic [zrbd_pkg::LEN_W-1:0]  rem;
   logic [zrbd_pkg::LEN_W-1:0]  run_n;
   logic                        run_clip;
   logic                        app_en;
   logic [zrbd_pkg::BYTE_W-1:0] app_byte;
   logic                        app_ov;
   logic [zrbd_pkg::WORD_W-1:0] acc;
   logic [zrbd_pkg::CNT_W-1:0]  acc_cnt;
   logic [zrbd_pkg::LEN_W-1:0]  pos_next;
   logic                        row_done;

   // clamp written length into 1..cap
   always_comb begin
      len_in = len_ff;
      if (csr_valid) begin
         if (csr_data == '0)         len_in = zrbd_pkg::LEN_W'(1);
         else if (csr_data > LEN_CAP) len_in = LEN_CAP;
         else                        len_in = csr_data;
      end
   end

   // run length after clipping at the row end
   assign rem      = (pos_ff < len_ff) ? (len_ff - pos_ff) : zrbd_pkg::LEN_W'(1);
   assign run_clip = {1'b0, in_byte} > rem;
   assign run_n    = run_clip ? rem : {1'b0, in_byte};

   assign status.out_free   = !out_vld_ff || rsp_tready;
   assign status.starts_run = (req_type == zrbd_pkg::REQ_NO_DATA) ||
                              (awaiting_ff && (in_byte != '0));
   assign status.run_last   = (run_cnt_ff == zrbd_pkg::LEN_W'(1));

   assign app_en   = cmd.run_step ||
                     (cmd.take_item && (req_type == zrbd_pkg::REQ_DATA) &&
                      !awaiting_ff && (in_byte != '0));
   assign app_byte = cmd.run_step ? run_byte_ff : in_byte;
   assign app_ov   = cmd.run_step ? run_ov_ff : 1'b0;

   assign acc      = {8'h00, buf_ff} |
                     ({56'h0, app_byte} << {fill_ff, 3'b000});
   assign acc_cnt  = {1'b0, fill_ff} + zrbd_pkg::CNT_W'(1);
   assign pos_next = pos_ff + zrbd_pkg::LEN_W'(1);
   assign row_done = pos_next >= len_ff;

   always_comb begin
      awaiting_in = awaiting_ff;
      pos_in      = pos_ff;
      buf_in      = buf_ff;
      fill_in     = fill_ff;
      run_cnt_in  = run_cnt_ff;
      run_byte_in = run_byte_ff;
      run_ov_in   = run_ov_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_word_in = out_word_ff;
      out_cnt_in  = out_cnt_ff;
      out_end_in  = out_end_ff;
      out_ov_in   = out_ov_ff;

      if (cmd.take_item) begin
         if (req_type == zrbd_pkg::REQ_NO_DATA) begin
            // drop any partial row, then a full row of ones
            awaiting_in = 1'b0;
            pos_in      = '0;
            buf_in      = '0;
            fill_in     = '0;
            run_cnt_in  = len_ff;
            run_byte_in = zrbd_pkg::NOVIS_BYTE;
            run_ov_in   = 1'b0;
         end else if (awaiting_ff) begin
            awaiting_in = 1'b0;
            run_cnt_in  = run_n;
            run_byte_in = '0;
            run_ov_in   = run_clip;
         end else if (in_byte == '0) begin
            awaiting_in = 1'b1;
         end
      end

      if (cmd.run_step) run_cnt_in = run_cnt_ff - zrbd_pkg::LEN_W'(1);

      if (app_en) begin
         pos_in = pos_next;
         if ((acc_cnt == zrbd_pkg::CNT_W'(8)) || row_done) begin
            out_vld_in  = 1'b1;
            out_word_in = acc;
            out_cnt_in  = acc_cnt;
            out_end_in  = row_done;
            out_ov_in   = row_done && app_ov;
            buf_in      = '0;
            fill_in     = '0;
         end else begin
            buf_in  = acc[zrbd_pkg::BUF_W-1:0];
            fill_in = acc_cnt[zrbd_pkg::FILL_W-1:0];
         end
         if (row_done) begin
            pos_in      = '0;
            awaiting_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= zrbd_pkg::LEN_W'(1);
         awaiting_ff <= 1'b0;
         pos_ff      <= '0;
         buf_ff      <= '0;
         fill_ff     <= '0;
         run_cnt_ff  <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         len_ff      <= len_in;
         awaiting_ff <= awaiting_in;
         pos_ff      <= pos_in;
         buf_ff      <= buf_in;
         fill_ff     <= fill_in;
         run_cnt_ff  <= run_cnt_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      run_ov_ff   <= run_ov_in;
      out_word_ff <= out_word_in;
      out_cnt_ff  <= out_cnt_in;
      out_end_ff  <= out_end_in;
      out_ov_ff   <= out_ov_in;
   end

   assign rsp_tvalid      = out_vld_ff;
   assign rsp_word        = out_word_ff;
   assign rsp_bytes_valid = out_cnt_ff;
   assign rsp_row_end     = out_end_ff;
   assign rsp_overrun     = out_ov_ff;

endmodule

/* rtl/zero_run_bitset_decoder.sv */
// Zero-run bitset row decoder, top level.
// Decodes one visibility row from a zero-run byte stream into 64-bit words,
// first byte in the low bits. A literal byte, a zero marker or a zero count
// is a single input transfer. A run count of n (after clipping at the row end)
// is the count transfer, then n bytes at one byte per cycle while the output
// register is free, with input held off. A no-data row runs the same way for
// row length bytes of ones. Each finished word (eight bytes, or the last word
// of a row) moves to a one-word output register; while a word waits there
// untaken, input transfers and run bytes are held off until it is accepted.
// The row length is written on the csr channel (always ready), clamped to
// 1..min(ROW_BYTES_MAX,256); write it only while the decoder is idle.
module zero_run_bitset_decoder #(
   parameter int unsigned ROW_BYTES_MAX = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [zrbd_pkg::LEN_W-1:0]         csr_data,     // row_bytes
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,    // in_byte
   input  logic                               req_tuser,    // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [zrbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,    // word, bytes_valid, zero pad
   output logic                               rsp_tlast,    // row_end
   output logic                               rsp_tuser     // overrun
);

   zrbd_pkg::ctl_cmd_type   cmd;
   zrbd_pkg::dp_status_type status;

   logic [zrbd_pkg::WORD_W-1:0] rsp_word;
   logic [zrbd_pkg::CNT_W-1:0]  rsp_bytes_valid;

   assign csr_ready = 1'b1;

   zrbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   zrbd_datapath #(
      .ROW_BYTES_MAX (ROW_BYTES_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .req_type        (req_tuser),
      .in_byte         (req_tdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_word        (rsp_word),
      .rsp_bytes_valid (rsp_bytes_valid),
      .rsp_row_end     (rsp_tlast),
      .rsp_overrun     (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, rsp_bytes_valid, rsp_word};

endmodule

/* rtl/zrbd_checker.sv */
// Port-level checks for the zero-run bitset row decoder, bound to the top.
module zrbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [zrbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[67:64] != 4'd0) && (rsp_tdata[67:64] <= 4'd8))
      else $error("bytes_valid out of range");

   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[67:64] == 4'd8))
      else $error("short word before row end");

   a_overrun_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("overrun on a word that does not end the row");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[71:68] == 4'd0))
      else $error("pad bits set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) &&
                                      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind zero_run_bitset_decoder zrbd_checker u_zrbd_checker (.*);

/* tb/zero_run_bitset_decoder_tb.sv */
// Self-checking testbench for the zero-run bitset row decoder: directed table, then random streams.
`timescale 1ns / 1ps

module zero_run_bitset_decoder_tb;

   localparam int unsigned ROW_MAX         = 256;
   localparam int          DRAIN_CYCLES    = 40;
   localparam int          HOLD_CYCLES     = 300;
   localparam int unsigned ITEMS_PER_PHASE = 50;

   typedef struct packed {
      logic [zrbd_pkg::WORD_W-1:0] word;
      logic [zrbd_pkg::CNT_W-1:0]  bytes_valid;
      logic                        row_end;
      logic                        overrun;
   } row_word_type;

   typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_type;

   typedef struct {
      step_kind_type               kind;
      logic                        req_type;
      logic [zrbd_pkg::BYTE_W-1:0] in_byte;
      logic [zrbd_pkg::LEN_W-1:0]  cfg_value;
      bit                          typed;
      row_word_type                typed_word;
   } step_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [zrbd_pkg::LEN_W-1:0]      csr_data   = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;
   logic                            req_tuser  = zrbd_pkg::REQ_DATA;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [zrbd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   // decoder state as predicted
   logic [zrbd_pkg::LEN_W-1:0]  row_len_reg = zrbd_pkg::LEN_W'(1);
   bit                          pend_marker;
   logic [zrbd_pkg::LEN_W-1:0]  row_pos;
   logic [zrbd_pkg::BUF_W-1:0]  pack_buf;
   logic [zrbd_pkg::FILL_W-1:0] pack_cnt;
   row_word_type                decoded_q[$];
   row_word_type                expected_words[$];
   step_type                    directed_steps[$];

   int   errors        = 0;
   int   send_idle_pct = 35;
   int   recv_idle_pct = 48;
   logic hold_armed    = 1'b0;
   int   hold_left     = 0;
   bit   hold_done     = 0;

   zero_run_bitset_decoder #(.ROW_BYTES_MAX(ROW_MAX)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned row_len_eff();
      int unsigned n = row_len_reg;
      if (n == 0) n = 1;
      if (n > ROW_MAX) n = ROW_MAX;
      if (n > 256) n = 256;
      return n;
   endfunction

   function automatic void start_row();
      pend_marker = 0;
      row_pos     = '0;
      pack_buf    = '0;
      pack_cnt    = '0;
   endfunction

   // append one decoded byte; returns 1 when the row closes
   function automatic bit pack_byte(logic [7:0] b, int unsigned len, logic ov);
      logic [zrbd_pkg::WORD_W-1:0] acc;
      int unsigned                 cnt;
      bit                          row_done;
      acc      = {8'h00, pack_buf} | (64'(b) << (8 * pack_cnt));
      cnt      = pack_cnt + 1;
      row_pos  = row_pos + zrbd_pkg::LEN_W'(1);
      row_done = (row_pos >= len);
      if (cnt == 8 || row_done) begin
         decoded_q.push_back('{word: acc, bytes_valid: zrbd_pkg::CNT_W'(cnt),
                               row_end: row_done, overrun: row_done ? ov : 1'b0});
         pack_buf = '0;
         pack_cnt = '0;
      end else begin
         pack_buf = acc[zrbd_pkg::BUF_W-1:0];
         pack_cnt = zrbd_pkg::FILL_W'(cnt);
      end
      if (row_done) start_row();
      return row_done;
   endfunction

   function automatic void decode_item(logic req_type, logic [7:0] in_byte);
      int unsigned len;
      int unsigned room;
      int unsigned n;
      logic        ov;
      len = row_len_eff();
      decoded_q.delete();
      if (req_type == zrbd_pkg::REQ_NO_DATA) begin
         start_row();
         for (int i = 0; i < len; i++)
            if (pack_byte(zrbd_pkg::NOVIS_BYTE, len, 1'b0)) break;
      end else if (pend_marker) begin
         pend_marker = 0;
         // position already past a lowered length: one byte closes the row
         room = (row_pos < len) ? len - row_pos : 1;
         n    = in_byte;
         ov   = 1'b0;
         if (n > room) begin
            n  = room;
            ov = 1'b1;
         end
         for (int i = 0; i < n; i++)
            if (pack_byte(8'h00, len, ov)) break;
      end else if (in_byte == 8'h00) begin
         pend_marker = 1;
      end else begin
         void'(pack_byte(in_byte, len, 1'b0));
      end
   endfunction

   function automatic void add_item(logic t, logic [7:0] b);
      directed_steps.push_back('{kind: STEP_ITEM, req_type: t, in_byte: b, cfg_value: '0,
                                 typed: 0, typed_word: '0});
   endfunction

   function automatic void add_typed(logic t, logic [7:0] b, logic [63:0] w, logic [3:0] v,
                                     logic e, logic o);
      directed_steps.push_back('{kind: STEP_ITEM, req_type: t, in_byte: b, cfg_value: '0,
                                 typed: 1, typed_word: '{word: w, bytes_valid: v,
                                                         row_end: e, overrun: o}});
   endfunction

   function automatic void add_cfg(logic [zrbd_pkg::LEN_W-1:0] v);
      directed_steps.push_back('{kind: STEP_CFG, req_type: zrbd_pkg::REQ_DATA, in_byte: '0,
                                 cfg_value: v, typed: 0, typed_word: '0});
   endfunction

   // offer one item, optionally after a gap; valid stays high into the next call
   task automatic send_req(logic req_type, logic [7:0] in_byte, bit typed,
                           row_word_type typed_word);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req_type;
      req_tdata  <= in_byte;
      do @(posedge clock); while (!req_tready);
      decode_item(req_type, in_byte);
      if (typed)
         expected_words.push_back(typed_word);
      else
         foreach (decoded_q[i]) expected_words.push_back(decoded_q[i]);
   endtask

   task automatic write_row_len(logic [zrbd_pkg::LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      // a run may still be filling a partial word
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      row_len_reg = value;
   endtask

   task automatic run_random_phase(int unsigned n_items);
      int unsigned  sent = 0;
      int unsigned  pick;
      logic [7:0]   run_len;
      row_word_type none = '0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_req(zrbd_pkg::REQ_NO_DATA, 8'($urandom), 0, none);
            sent++;
         end else if (pick < 60) begin
            send_req(zrbd_pkg::REQ_DATA, 8'($urandom_range(1, 255)), 0, none);
            sent++;
         end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0)
               run_len = 8'($urandom_range(0, 255));
            else
               run_len = 8'($urandom_range(0, 12));
            send_req(zrbd_pkg::REQ_DATA, 8'h00, 0, none);
            send_req(zrbd_pkg::REQ_DATA, run_len, 0, none);
            sent += 2;
         end else begin
            // noise: stray markers, broken pairs, raw bytes of either kind
            send_req(1'($urandom_range(0, 1)), 8'($urandom), 0, none);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      row_word_type got;
      row_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{word: rsp_tdata[zrbd_pkg::WORD_W-1:0],
                    bytes_valid: rsp_tdata[zrbd_pkg::WORD_W+zrbd_pkg::CNT_W-1:zrbd_pkg::WORD_W],
                    row_end: rsp_tlast, overrun: rsp_tuser};
            if (expected_words.size() == 0) begin
               $error("result transfer with nothing expected: word %h", got.word);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got.word !== want.word) begin
                  $error("word: expected %h, got %h", want.word, got.word);
                  errors++;
               end
               if (got.bytes_valid !== want.bytes_valid) begin
                  $error("bytes_valid: expected %0d, got %0d", want.bytes_valid, got.bytes_valid);
                  errors++;
               end
               if (got.row_end !== want.row_end) begin
                  $error("row_end: expected %b, got %b", want.row_end, got.row_end);
                  errors++;
               end
               if (got.overrun !== want.overrun) begin
                  $error("overrun: expected %b, got %b", want.overrun, got.overrun);
                  errors++;
               end
            end
         end
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      start_row();

      // reset row length of one byte
      add_typed(zrbd_pkg::REQ_DATA,    8'h5A, 64'h5A, 4'd1, 1'b1, 1'b0);
      add_typed(zrbd_pkg::REQ_DATA,    8'hFF, 64'hFF, 4'd1, 1'b1, 1'b0);
      add_typed(zrbd_pkg::REQ_NO_DATA, 8'h00, 64'hFF, 4'd1, 1'b1, 1'b0);
      add_item (zrbd_pkg::REQ_DATA,    8'h00);
      add_typed(zrbd_pkg::REQ_DATA,    8'h05, 64'h00, 4'd1, 1'b1, 1'b1);
      // zero length acts as one
      add_cfg(9'd0);
      add_typed(zrbd_pkg::REQ_DATA,    8'h01, 64'h01, 4'd1, 1'b1, 1'b0);
      // full-size rows
      add_cfg(9'd256);
      add_item(zrbd_pkg::REQ_NO_DATA, 8'hFF);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'h80);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'hFF);
      add_item(zrbd_pkg::REQ_DATA, 8'h02);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'hFF);
      // length above the maximum clamps; no-data request drops the open row
      add_cfg(9'd511);
      add_item(zrbd_pkg::REQ_DATA, 8'h11);
      add_item(zrbd_pkg::REQ_DATA, 8'h22);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_NO_DATA, 8'h55);
      // length lowered below the open row position
      add_cfg(9'd12);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'h09);
      add_cfg(9'd4);
      add_item(zrbd_pkg::REQ_DATA, 8'h00);
      add_item(zrbd_pkg::REQ_DATA, 8'h03);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CFG)
            write_row_len(directed_steps[i].cfg_value);
         else
            send_req(directed_steps[i].req_type, directed_steps[i].in_byte,
                     directed_steps[i].typed, directed_steps[i].typed_word);
      end

      write_row_len(9'($urandom_range(1, 24)));
      run_random_phase(ITEMS_PER_PHASE);

      write_row_len(9'($urandom_range(1, 64)));
      send_idle_pct = 48;
      recv_idle_pct <= 35;
      run_random_phase(ITEMS_PER_PHASE);

      write_row_len(9'($urandom_range(1, 511)));
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_armed    <= 1'b1;
      run_random_phase(ITEMS_PER_PHASE);

      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* zero_run_bitset_decoder.f */
rtl/zrbd_pkg.sv
rtl/zrbd_ctrl.sv
rtl/zrbd_datapath.sv
rtl/zero_run_bitset_decoder.sv
rtl/zrbd_checker.sv
tb/zero_run_bitset_decoder_tb.sv
